/* sv/tbd_pkg.sv */
package tbd_pkg;

  // default fraction bits of the Q format
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned PADDR_W = 2;
  localparam logic [30:0] FAR_DEPTH_RST = 31'h7FFF_FFFF;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] vert0_x;
    logic signed [31:0] vert0_y;
    logic signed [31:0] vert0_z;
    logic signed [31:0] vert1_x;
    logic signed [31:0] vert1_y;
    logic signed [31:0] vert1_z;
    logic signed [31:0] vert2_x;
    logic signed [31:0] vert2_y;
    logic signed [31:0] vert2_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               command;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] gamma;
    logic signed [31:0] depth;
    logic               outside;
    logic               degenerate;
  } out_item_t;

  // per-item data carried alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] z0;
    logic signed [31:0] z1;
    logic signed [31:0] z2;
    logic               face;
    logic               degen;
    logic               nega;
    logic               negb;
    logic               ovfa;
    logic               ovfb;
  } side_t;

  // magnitude quotient plus overflow and sign to saturated signed weight
  function automatic logic [31:0] sat_weight(logic [31:0] q, logic ovf, logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (ovf || (q > SAT_MIN)) ? SAT_MIN : (32'd0 - q);
    end else begin
      r = (ovf || q[31]) ? SAT_MAX : q;
    end
    return r;
  endfunction

endpackage

/* sv/tbd_stream_if.sv */
interface tbd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/triangle_barycentric_depth.sv */
// Channel   Dir  Handshake       Payload
// in_i      in   valid / ready   tbd_pkg::in_item_t  (vertices, point, command)
// out_o     out  valid / ready   tbd_pkg::out_item_t (weights, depth, flags)
// apb       in   psel / penable  far_depth at any address (paddr ignored), pready tied high
//
// One transaction per clock while out_o is not stalled; the pipe is built around
// the 32 restoring-division stages (one quotient bit each) for alpha and beta.
// Reset (rst_ni, async, low) clears all valid bits and sets far_depth to max.
// A stall on out_o freezes the whole pipe; in_i.ready follows out_o.ready
// whenever the output register is full.
module triangle_barycentric_depth #(
  parameter int unsigned FRAC_BITS = tbd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tbd_stream_if.sink                  in_i,
  tbd_stream_if.source                out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // widths: coordinate differences, products, determinants
  localparam int unsigned DW   = 33;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned MAGW = PW + 1;
  // division remainder: below divisor << 32 once overflow is ruled out
  localparam int unsigned RW   = MAGW + 32;
  localparam int unsigned NST  = 41;
  // stage numbers
  localparam int unsigned ST_DIV0 = 5;
  localparam int unsigned ST_WGT  = 38;
  localparam int unsigned ST_GAM  = 39;
  localparam int unsigned ST_MUL  = 40;

  // ---------------------------------------------------------------------------
  // configuration: single register, every write hits far_depth
  // ---------------------------------------------------------------------------
  logic [30:0] far_q, far_d;

  assign pready = 1'b1;
  assign prdata = {1'b0, far_q};

  always_comb begin
    far_d = far_q;
    if (psel && penable && pwrite) begin
      far_d = pwdata[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_q <= tbd_pkg::FAR_DEPTH_RST;
    end else begin
      far_q <= far_d;
    end
  end

  // addresses are ignored with only one register present
  logic unused_addr;
  assign unused_addr = ^paddr ^ ^pwdata[31];

  // ---------------------------------------------------------------------------
  // pipeline control: whole pipe advances unless the output is held
  // ---------------------------------------------------------------------------
  logic             adv;
  logic [NST:1]     vld_q, vld_d;

  assign adv       = !vld_q[NST] || out_o.ready;
  assign in_i.ready = adv;
  assign vld_d     = adv ? {vld_q[NST-1:1], in_i.valid} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // side data shift line, stage 1 to stage 40
  tbd_pkg::side_t side_q [1:ST_MUL];
  tbd_pkg::side_t side4_d, side5_d;

  // stage 1: differences against vertex 2
  logic signed [DW-1:0] dx0_q, dx1_q, dpx_q, dy0_q, dy1_q, dpy_q;
  // stage 2: six products
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  // stage 3: determinant and partial determinants
  logic signed [MAGW-1:0] det_q, da_q, db_q;
  // stage 4: magnitudes
  logic [MAGW-1:0] namag_q, nbmag_q;
  logic [MAGW-1:0] dmag_q [4:ST_WGT-2];
  // divider state, index 5 is the loaded value
  logic [RW-1:0] rema_q [ST_DIV0:ST_WGT-2];
  logic [RW-1:0] remb_q [ST_DIV0:ST_WGT-2];
  logic [31:0]   qa_q   [ST_DIV0:ST_WGT-1];
  logic [31:0]   qb_q   [ST_DIV0:ST_WGT-1];
  // weight stages
  logic signed [31:0] a38_q, b38_q, a39_q, b39_q, g39_q, a40_q, b40_q, g40_q;
  logic signed [63:0] pa_q, pb_q, pc_q;
  tbd_pkg::out_item_t out_q;

  logic [RW-1:0] num_a, num_b, den_sh;
  logic signed [33:0] g_full;
  logic signed [31:0] g_sat;
  logic signed [65:0] dsum, dsh;
  logic signed [31:0] dsat;
  logic outside;

  always_comb begin
    num_a  = {{(RW-MAGW-FRAC_BITS){1'b0}}, namag_q, {FRAC_BITS{1'b0}}};
    num_b  = {{(RW-MAGW-FRAC_BITS){1'b0}}, nbmag_q, {FRAC_BITS{1'b0}}};
    den_sh = {dmag_q[4], 32'd0};

    // stage 4 flags: degenerate and quotient signs
    side4_d       = side_q[3];
    side4_d.degen = (det_q == '0);
    side4_d.nega  = da_q[MAGW-1] ^ det_q[MAGW-1];
    side4_d.negb  = db_q[MAGW-1] ^ det_q[MAGW-1];
    // stage 5 flags: quotient would not fit in 32 bits
    side5_d      = side_q[4];
    side5_d.ovfa = (num_a >= den_sh);
    side5_d.ovfb = (num_b >= den_sh);

    g_full = (34'sd1 <<< FRAC_BITS) - {{2{a38_q[31]}}, a38_q} - {{2{b38_q[31]}}, b38_q};
    if (g_full[33:31] == 3'b000 || g_full[33:31] == 3'b111) begin
      g_sat = g_full[31:0];
    end else begin
      g_sat = g_full[33] ? tbd_pkg::SAT_MIN : tbd_pkg::SAT_MAX;
    end

    dsum = {{2{pa_q[63]}}, pa_q} + {{2{pb_q[63]}}, pb_q} + {{2{pc_q[63]}}, pc_q};
    dsh  = dsum >>> FRAC_BITS;
    if ((&dsh[65:31]) || !(|dsh[65:31])) begin
      dsat = dsh[31:0];
    end else begin
      dsat = dsh[65] ? tbd_pkg::SAT_MIN : tbd_pkg::SAT_MAX;
    end

    outside = side_q[ST_MUL].face && !side_q[ST_MUL].degen &&
              (a40_q[31] || b40_q[31] || g40_q[31]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // side line
      side_q[1].z0    <= in_i.data.vert0_z;
      side_q[1].z1    <= in_i.data.vert1_z;
      side_q[1].z2    <= in_i.data.vert2_z;
      side_q[1].face  <= in_i.data.command;
      side_q[1].degen <= 1'b0;
      side_q[1].nega  <= 1'b0;
      side_q[1].negb  <= 1'b0;
      side_q[1].ovfa  <= 1'b0;
      side_q[1].ovfb  <= 1'b0;
      for (int k = 2; k <= ST_MUL; k++) begin
        if (k == 4) begin
          side_q[k] <= side4_d;
        end else if (k == ST_DIV0) begin
          side_q[k] <= side5_d;
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end

      // stage 1
      dx0_q <= {in_i.data.vert0_x[31], in_i.data.vert0_x} -
               {in_i.data.vert2_x[31], in_i.data.vert2_x};
      dx1_q <= {in_i.data.vert1_x[31], in_i.data.vert1_x} -
               {in_i.data.vert2_x[31], in_i.data.vert2_x};
      dpx_q <= {in_i.data.point_x[31], in_i.data.point_x} -
               {in_i.data.vert2_x[31], in_i.data.vert2_x};
      dy0_q <= {in_i.data.vert0_y[31], in_i.data.vert0_y} -
               {in_i.data.vert2_y[31], in_i.data.vert2_y};
      dy1_q <= {in_i.data.vert1_y[31], in_i.data.vert1_y} -
               {in_i.data.vert2_y[31], in_i.data.vert2_y};
      dpy_q <= {in_i.data.point_y[31], in_i.data.point_y} -
               {in_i.data.vert2_y[31], in_i.data.vert2_y};

      // stage 2
      p1_q <= dx0_q * dy1_q;
      p2_q <= dx1_q * dy0_q;
      p3_q <= dpx_q * dy1_q;
      p4_q <= dx1_q * dpy_q;
      p5_q <= dx0_q * dpy_q;
      p6_q <= dpx_q * dy0_q;

      // stage 3
      det_q <= {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
      da_q  <= {p3_q[PW-1], p3_q} - {p4_q[PW-1], p4_q};
      db_q  <= {p5_q[PW-1], p5_q} - {p6_q[PW-1], p6_q};

      // stage 4: magnitudes
      dmag_q[4]    <= det_q[MAGW-1] ? MAGW'(-det_q) : MAGW'(det_q);
      namag_q      <= da_q[MAGW-1] ? MAGW'(-da_q) : MAGW'(da_q);
      nbmag_q      <= db_q[MAGW-1] ? MAGW'(-db_q) : MAGW'(db_q);
      for (int k = 5; k <= ST_WGT - 2; k++) begin
        dmag_q[k] <= dmag_q[k-1];
      end

      // stage 5: divider load
      rema_q[ST_DIV0]      <= num_a;
      remb_q[ST_DIV0]      <= num_b;
      qa_q[ST_DIV0]        <= '0;
      qb_q[ST_DIV0]        <= '0;

      // stage 38: sign and saturation
      a38_q <= tbd_pkg::sat_weight(qa_q[ST_WGT-1], side_q[ST_WGT-1].ovfa,
                                   side_q[ST_WGT-1].nega);
      b38_q <= tbd_pkg::sat_weight(qb_q[ST_WGT-1], side_q[ST_WGT-1].ovfb,
                                   side_q[ST_WGT-1].negb);

      // stage 39: gamma
      a39_q <= a38_q;
      b39_q <= b38_q;
      g39_q <= g_sat;

      // stage 40: depth products
      a40_q <= a39_q;
      b40_q <= b39_q;
      g40_q <= g39_q;
      pa_q  <= a39_q * side_q[ST_GAM].z0;
      pb_q  <= b39_q * side_q[ST_GAM].z1;
      pc_q  <= g39_q * side_q[ST_GAM].z2;

      // stage 41: output register
      out_q.degenerate <= side_q[ST_MUL].degen;
      out_q.outside    <= outside;
      if (side_q[ST_MUL].degen) begin
        out_q.alpha <= '0;
        out_q.beta  <= '0;
        out_q.gamma <= '0;
        out_q.depth <= '0;
      end else begin
        out_q.alpha <= a40_q;
        out_q.beta  <= b40_q;
        out_q.gamma <= g40_q;
        out_q.depth <= outside ? (32'd0 - {1'b0, far_q}) : dsat;
      end
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < 32; k++) begin : g_div
    logic [RW:0] ta, tb;
    logic [31:0] qa_n, qb_n;

    assign ta = {1'b0, rema_q[ST_DIV0+k]} -
                ({1'b0, {(RW-MAGW){1'b0}}, dmag_q[ST_DIV0+k]} << (31 - k));
    assign tb = {1'b0, remb_q[ST_DIV0+k]} -
                ({1'b0, {(RW-MAGW){1'b0}}, dmag_q[ST_DIV0+k]} << (31 - k));

    always_comb begin
      qa_n         = qa_q[ST_DIV0+k];
      qa_n[31-k]   = !ta[RW];
      qb_n         = qb_q[ST_DIV0+k];
      qb_n[31-k]   = !tb[RW];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        qa_q[ST_DIV0+k+1] <= qa_n;
        qb_q[ST_DIV0+k+1] <= qb_n;
      end
    end

    if (k < 31) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rema_q[ST_DIV0+k+1] <= ta[RW] ? rema_q[ST_DIV0+k] : ta[RW-1:0];
          remb_q[ST_DIV0+k+1] <= tb[RW] ? remb_q[ST_DIV0+k] : tb[RW-1:0];
        end
      end
    end
  end

  assign out_o.valid = vld_q[NST];
  assign out_o.data  = out_q;

endmodule

/* test/tb_triangle_barycentric_depth.sv */
`timescale 1ns / 1ps

module tb_triangle_barycentric_depth;

  localparam int unsigned FB = tbd_pkg::FRAC_BITS_DEF;
  localparam int unsigned N_RANDOM = 456;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned LONG_HOLD = 120;
  localparam logic [tbd_pkg::PADDR_W-1:0] ADDR_FAR_DEPTH = '0;
  localparam logic CMD_PLANE = 1'b0;
  localparam logic CMD_FACE = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tbd_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tbd_stream_if #(.T(tbd_pkg::in_item_t)) query_if ();
  tbd_stream_if #(.T(tbd_pkg::out_item_t)) depth_if ();

  triangle_barycentric_depth uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (query_if),
    .out_o   (depth_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns period
  always #10 clk_i = ~clk_i;

  // shadow of the far-depth register, kept in step with APB writes
  logic [30:0] far_depth_q = tbd_pkg::FAR_DEPTH_RST;

  tbd_pkg::out_item_t expected_q[$];
  int unsigned n_fail = 0;
  int unsigned n_checked = 0;
  int unsigned n_outside = 0;
  int unsigned n_degen = 0;

  // receiver controls
  bit idle_enable = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;
  int unsigned hold_cycles = 0;
  bit stim_done = 1'b0;

  // ------------------------------------------------------------------
  // Predictor: exact integer maths at widths big enough to never wrap.
  // ------------------------------------------------------------------
  function automatic logic signed [31:0] sat_to_q(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // truncated (num << FB) / den, then saturated
  function automatic logic signed [31:0] bary_weight(logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FB) / den; // SV signed division truncates toward zero
    return sat_to_q(q);
  endfunction

  function automatic tbd_pkg::out_item_t predict_depth(tbd_pkg::in_item_t q);
    tbd_pkg::out_item_t r;
    logic signed [127:0] x0, y0, x1, y1, x2, y2, px, py;
    logic signed [127:0] det, da, db, s, g;
    x0 = 128'(q.vert0_x); y0 = 128'(q.vert0_y);
    x1 = 128'(q.vert1_x); y1 = 128'(q.vert1_y);
    x2 = 128'(q.vert2_x); y2 = 128'(q.vert2_y);
    px = 128'(q.point_x); py = 128'(q.point_y);
    det = (x0 - x2) * (y1 - y2) - (x1 - x2) * (y0 - y2);
    da = (px - x2) * (y1 - y2) - (x1 - x2) * (py - y2);
    db = (x0 - x2) * (py - y2) - (px - x2) * (y0 - y2);
    r = '0;
    r.degenerate = (det == 0);
    if (det != 0) begin
      r.alpha = bary_weight(da, det);
      r.beta = bary_weight(db, det);
      g = (128'sd1 <<< FB) - 128'(r.alpha) - 128'(r.beta);
      r.gamma = sat_to_q(g);
      s = 128'(r.alpha) * 128'(q.vert0_z) + 128'(r.beta) * 128'(q.vert1_z)
        + 128'(r.gamma) * 128'(q.vert2_z);
      r.depth = sat_to_q(s >>> FB);
      if (q.command == CMD_FACE && (r.alpha < 0 || r.beta < 0 || r.gamma < 0)) begin
        r.outside = 1'b1;
        r.depth = -$signed({1'b0, far_depth_q});
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------
  task automatic send_query(tbd_pkg::in_item_t q, bit allow_idle);
    int unsigned gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      query_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_if.data <= q;
    query_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!query_if.ready) @(posedge clk_i);
    // accepted at this edge: book the expectation
    expected_q.push_back(predict_depth(q));
  endtask

  task automatic stop_sending();
    query_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write_far(logic [30:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_FAR_DEPTH; pwdata <= {1'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    far_depth_q = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int unsigned mode);
    case (mode)
      0: return $urandom();                                // full range
      1: return 32'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic tbd_pkg::in_item_t rand_query();
    tbd_pkg::in_item_t q;
    int unsigned m;
    m = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
    q.vert0_x = rand_coord(m); q.vert0_y = rand_coord(m); q.vert0_z = $urandom();
    q.vert1_x = rand_coord(m); q.vert1_y = rand_coord(m); q.vert1_z = $urandom();
    q.vert2_x = rand_coord(m); q.vert2_y = rand_coord(m); q.vert2_z = $urandom();
    q.point_x = rand_coord(m); q.point_y = rand_coord(m);
    q.command = 1'($urandom_range(0, 1));
    // a few collinear triangles for the degenerate path
    if ($urandom_range(0, 19) == 0) begin
      q.vert2_x = q.vert1_x; q.vert2_y = q.vert1_y;
    end
    return q;
  endfunction

  // directed table: a unit right triangle with depths 1, 2, 3 plus extremes
  localparam int ONE = 1 << FB;
  typedef struct {
    tbd_pkg::in_item_t q;
    bit has_exp;
    tbd_pkg::out_item_t r;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic tbd_pkg::in_item_t mk(int x0, int y0, int z0, int x1, int y1, int z1,
                                           int x2, int y2, int z2, int px, int py,
                                           logic c);
    tbd_pkg::in_item_t q;
    q = {x0, y0, z0, x1, y1, z1, x2, y2, z2, px, py, c};
    return q;
  endfunction

  function automatic tbd_pkg::out_item_t mk_exp(int a, int b, int g, int d, logic o,
                                                logic dg);
    tbd_pkg::out_item_t r;
    r = {a, b, g, d, o, dg};
    return r;
  endfunction

  task automatic build_directed();
    dir_row_t row;
    // point on vertex 2: weights (0,0,1), depth z2
    row.q = mk(ONE, 0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, 0, 0, CMD_PLANE);
    row.has_exp = 1; row.r = mk_exp(0, 0, ONE, 3 * ONE, 0, 0); dir_rows.push_back(row);
    // point on vertex 0 in face mode
    row.q = mk(ONE, 0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE, 0, CMD_FACE);
    row.r = mk_exp(ONE, 0, 0, ONE, 0, 0); dir_rows.push_back(row);
    // all-zero triangle: degenerate
    row.q = '0; row.r = mk_exp(0, 0, 0, 0, 0, 1); dir_rows.push_back(row);
    row.q.command = CMD_FACE; dir_rows.push_back(row);
    // outside in face mode with reset far depth
    row.q = mk(ONE, 0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, -ONE, 0, CMD_FACE);
    row.r = mk_exp(-ONE, 0, 2 * ONE, 32'sh8000_0001, 1, 0); dir_rows.push_back(row);
    // same point in plane mode: predictor checked
    row.has_exp = 0; row.q.command = CMD_PLANE; dir_rows.push_back(row);
    // extremes of every field
    row.q = {{11{32'sh7FFF_FFFF}}, 1'b1}; dir_rows.push_back(row);
    row.q = {{11{32'sh8000_0000}}, 1'b0}; dir_rows.push_back(row);
    row.q = mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, CMD_PLANE);
    dir_rows.push_back(row);
    row.q.command = CMD_FACE; dir_rows.push_back(row);
    // tiny triangle, far point: weights saturate
    row.q = mk(1, 0, 32'sh7FFF_FFFF, 0, 1, 32'sh8000_0000, 0, 0, 5,
               32'sh7FFF_FFFF, 32'sh8000_0000, CMD_PLANE);
    dir_rows.push_back(row);
    row.q.command = CMD_FACE; dir_rows.push_back(row);
    // centroid-like point with mixed depths
    row.q = mk(3 * ONE, 0, -ONE, 0, 3 * ONE, 7 * ONE, 0, 0, 32'sh7FFF_FFFF,
               ONE, ONE, CMD_FACE);
    dir_rows.push_back(row);
  endtask

  // ------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      depth_if.ready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      depth_if.ready <= 1'b0;
      hold_cycles <= LONG_HOLD;
    end else if (hold_cycles != 0) begin
      depth_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_enable && depth_if.ready && $urandom_range(0, 7) == 0) begin
      depth_if.ready <= 1'b0;
      hold_cycles <= $urandom_range(0, 9);
    end else begin
      depth_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tbd_pkg::out_item_t exp_r;
    tbd_pkg::out_item_t got;
    if (rst_ni && depth_if.valid && depth_if.ready) begin
      got = depth_if.data;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (got.outside) n_outside++;
        if (got.degenerate) n_degen++;
        if (got.alpha !== exp_r.alpha) begin
          $error("alpha: expected %0d, got %0d", exp_r.alpha, got.alpha); n_fail++;
        end
        if (got.beta !== exp_r.beta) begin
          $error("beta: expected %0d, got %0d", exp_r.beta, got.beta); n_fail++;
        end
        if (got.gamma !== exp_r.gamma) begin
          $error("gamma: expected %0d, got %0d", exp_r.gamma, got.gamma); n_fail++;
        end
        if (got.depth !== exp_r.depth) begin
          $error("depth: expected %0d, got %0d", exp_r.depth, got.depth); n_fail++;
        end
        if (got.outside !== exp_r.outside) begin
          $error("outside: expected %0b, got %0b", exp_r.outside, got.outside); n_fail++;
        end
        if (got.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %0b, got %0b", exp_r.degenerate, got.degenerate);
          n_fail++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    logic [30:0] far_settings[4];
    query_if.valid = 1'b0;
    query_if.data = '0;
    far_settings = '{31'd0, 31'h7FFF_FFFF, 31'h1234_5678, 31'd1};
    build_directed();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, reset far depth
    foreach (dir_rows[i]) begin
      send_query(dir_rows[i].q, 1'b1);
      if (dir_rows[i].has_exp && expected_q[$] != dir_rows[i].r) begin
        $error("table row %0d disagrees with predictor", i); n_fail++;
      end
    end
    stop_sending();
    wait_drained();

    // long receiver hold-off while queries keep coming, filling the pipe
    long_hold_req = 1'b1;
    for (int i = 0; i < 80; i++) send_query(rand_query(), 1'b0);
    stop_sending();
    wait_drained();

    // random phases over several far-depth settings
    foreach (far_settings[k]) begin
      apb_write_far(far_settings[k]);
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        if (k == 3 && i > N_RANDOM / 8) idle_enable = 1'b0;
        send_query(rand_query(), k != 3 || i <= N_RANDOM / 8);
      end
      stop_sending();
      wait_drained();
    end

    $display("Checked %0d results (%0d outside, %0d degenerate) over 4 far-depth settings.",
             n_checked, n_outside, n_degen);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
sv/tbd_pkg.sv
sv/tbd_stream_if.sv
sv/triangle_barycentric_depth.sv
test/tb_triangle_barycentric_depth.sv
